@@ hw/rtl/vgvs_pkg.sv @@
// ----------------------------------------------------------------------------
// vgvs_pkg
// Shared constants for the voxel grid visibility store: operation codes,
// neighbour step codes and stream field layout.
// ----------------------------------------------------------------------------
`default_nettype none

package vgvs_pkg;

    localparam int GRID_BITS_DEF  = 4;
    localparam int KIND_WIDTH_DEF = 8;

    localparam int OP_W   = 2;
    localparam int POS_W  = 4;
    localparam int KIND_W = 8;

    localparam logic [OP_W-1:0] OP_PLACE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam int S_OP_LSB   = 0;
    localparam int S_X_LSB    = S_OP_LSB + OP_W;
    localparam int S_Y_LSB    = S_X_LSB + POS_W;
    localparam int S_Z_LSB    = S_Y_LSB + POS_W;
    localparam int S_KIND_LSB = S_Z_LSB + POS_W;
    localparam int S_USED_W   = S_KIND_LSB + KIND_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    localparam int M_USED_W  = 1 + KIND_W + 1;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    localparam int NB_SEL_W = 3;
    localparam logic [NB_SEL_W-1:0] NB_CENTRE = 3'd0;
    localparam logic [NB_SEL_W-1:0] NB_XM     = 3'd1;
    localparam logic [NB_SEL_W-1:0] NB_XP     = 3'd2;
    localparam logic [NB_SEL_W-1:0] NB_YM     = 3'd3;
    localparam logic [NB_SEL_W-1:0] NB_YP     = 3'd4;
    localparam logic [NB_SEL_W-1:0] NB_ZM     = 3'd5;
    localparam logic [NB_SEL_W-1:0] NB_ZP     = 3'd6;
    localparam logic [NB_SEL_W-1:0] NB_END    = 3'd7;

endpackage

`default_nettype wire

@@ hw/rtl/vgvs_ram.sv @@
// ----------------------------------------------------------------------------
// vgvs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vgvs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vgvs_nbr_unit.sv @@
// ----------------------------------------------------------------------------
// vgvs_nbr_unit
// Shared neighbour address unit: one increment/decrement on the selected
// axis, grid bound check from the carry, and the packed cell address.
// ----------------------------------------------------------------------------
`default_nettype none

module vgvs_nbr_unit #(
    parameter int GRID_BITS = vgvs_pkg::GRID_BITS_DEF
) (
    input  wire logic [GRID_BITS-1:0]          base_x,
    input  wire logic [GRID_BITS-1:0]          base_y,
    input  wire logic [GRID_BITS-1:0]          base_z,
    input  wire logic [vgvs_pkg::NB_SEL_W-1:0] sel,
    output logic      [3*GRID_BITS-1:0]        addr,
    output logic                               in_grid
);
    import vgvs_pkg::*;

    logic [GRID_BITS-1:0] axis_val;
    logic [GRID_BITS:0]   delta;
    logic [GRID_BITS:0]   sum;
    logic [1:0]           axis;
    logic [GRID_BITS-1:0] nx, ny, nz;

    always_comb begin
        unique case (sel)
            NB_XM:   begin axis = 2'd0; delta = '1; end
            NB_XP:   begin axis = 2'd0; delta = (GRID_BITS+1)'(1); end
            NB_YM:   begin axis = 2'd1; delta = '1; end
            NB_YP:   begin axis = 2'd1; delta = (GRID_BITS+1)'(1); end
            NB_ZM:   begin axis = 2'd2; delta = '1; end
            NB_ZP:   begin axis = 2'd2; delta = (GRID_BITS+1)'(1); end
            default: begin axis = 2'd0; delta = '0; end
        endcase
    end

    always_comb begin
        unique case (axis)
            2'd1:    axis_val = base_y;
            2'd2:    axis_val = base_z;
            default: axis_val = base_x;
        endcase
    end

    assign sum     = {1'b0, axis_val} + delta;
    assign in_grid = ~sum[GRID_BITS];

    always_comb begin
        nx = base_x;
        ny = base_y;
        nz = base_z;
        unique case (axis)
            2'd1:    ny = sum[GRID_BITS-1:0];
            2'd2:    nz = sum[GRID_BITS-1:0];
            default: nx = sum[GRID_BITS-1:0];
        endcase
    end

    assign addr = {nz, ny, nx};

endmodule

`default_nettype wire

@@ hw/rtl/voxel_grid_visibility_store_core.sv @@
// ----------------------------------------------------------------------------
// voxel_grid_visibility_store_core
// Voxel grid with occupancy and block kind per cell. Place, delete or query
// one cell; the result gives occupancy, kind and face visibility.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: op, pos_x, pos_y, pos_z, block_kind
//  m_      | out | m_tvalid/m_tready  | m_tdata: present, kind_out, shown
//
// Each operation makes seven RAM reads (centre plus six neighbours) through
// the shared neighbour address unit, then a drain step and a result step;
// place and delete do a write step first, and an out-of-grid position goes
// straight to the result. After reset a clearing pass zeroes all
// 2**(3*GRID_BITS) cells (4096 at default) of the occupancy RAM with
// s_tready low. A result waiting on m_tready holds the final step only.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_grid_visibility_store_core #(
    parameter int GRID_BITS  = vgvs_pkg::GRID_BITS_DEF,
    parameter int KIND_WIDTH = vgvs_pkg::KIND_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // op[1:0], pos_x[5:2], pos_y[9:6], pos_z[13:10], block_kind[21:14]
    input  wire logic [vgvs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // present[0], kind_out[8:1], shown[9]
    output logic      [vgvs_pkg::M_TDATA_W-1:0] m_tdata
);
    import vgvs_pkg::*;

    localparam int AW = 3 * GRID_BITS;
    localparam int CELLS = 1 << AW;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [GRID_BITS-1:0]  bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic [KIND_WIDTH-1:0] kind_reg, kind_next;
    logic [NB_SEL_W-1:0]   iss_reg, iss_next;
    logic                  cap_vld_reg, cap_vld_next;
    logic                  cap_ctr_reg, cap_ctr_next;
    logic                  cap_in_reg, cap_in_next;
    logic                  occ_c_reg, occ_c_next;
    logic [KIND_WIDTH-1:0] kind_c_reg, kind_c_next;
    logic                  encl_reg, encl_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic [OP_W-1:0]       s_op;
    logic [POS_W-1:0]      s_x, s_y, s_z;
    logic [KIND_W-1:0]     s_kind;
    logic                  s_in_grid;
    logic                  s_fire;

    logic [AW-1:0]         nb_addr;
    logic                  nb_in_grid;

    logic                  occ_we, occ_wdata, occ_rdata;
    logic [AW-1:0]         occ_waddr;
    logic                  kind_we;
    logic [KIND_WIDTH-1:0] kind_rdata;

    logic                  res_present, res_shown;
    logic [KIND_W-1:0]     res_kind;

    assign s_op   = s_tdata[S_OP_LSB +: OP_W];
    assign s_x    = s_tdata[S_X_LSB +: POS_W];
    assign s_y    = s_tdata[S_Y_LSB +: POS_W];
    assign s_z    = s_tdata[S_Z_LSB +: POS_W];
    assign s_kind = s_tdata[S_KIND_LSB +: KIND_W];

    assign s_in_grid = ((32'(s_x) >> GRID_BITS) == 32'd0) &&
                       ((32'(s_y) >> GRID_BITS) == 32'd0) &&
                       ((32'(s_z) >> GRID_BITS) == 32'd0);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    vgvs_nbr_unit #(
        .GRID_BITS (GRID_BITS)
    ) u_nbr (
        .base_x  (bx_reg),
        .base_y  (by_reg),
        .base_z  (bz_reg),
        .sel     (iss_reg),
        .addr    (nb_addr),
        .in_grid (nb_in_grid)
    );

    assign occ_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign occ_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : {bz_reg, by_reg, bx_reg};
    assign occ_wdata = (state_reg == ST_WRITE) && (op_reg == OP_PLACE);
    assign kind_we   = (state_reg == ST_WRITE) && (op_reg == OP_PLACE);

    vgvs_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_occ_ram (
        .aclk    (aclk),
        .wr_en   (occ_we),
        .wr_addr (occ_waddr),
        .wr_data (occ_wdata),
        .rd_addr (nb_addr),
        .rd_data (occ_rdata)
    );

    vgvs_ram #(
        .WIDTH (KIND_WIDTH),
        .DEPTH (CELLS)
    ) u_kind_ram (
        .aclk    (aclk),
        .wr_en   (kind_we),
        .wr_addr ({bz_reg, by_reg, bx_reg}),
        .wr_data (kind_reg),
        .rd_addr (nb_addr),
        .rd_data (kind_rdata)
    );

    assign res_present = occ_c_reg;
    assign res_kind    = occ_c_reg ? KIND_W'(kind_c_reg) : '0;
    assign res_shown   = occ_c_reg && !encl_reg;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        op_next       = op_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        bz_next       = bz_reg;
        kind_next     = kind_reg;
        iss_next      = iss_reg;
        cap_vld_next  = 1'b0;
        cap_ctr_next  = cap_ctr_reg;
        cap_in_next   = cap_in_reg;
        occ_c_next    = occ_c_reg;
        kind_c_next   = kind_c_reg;
        encl_next     = encl_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == {AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    op_next    = s_op;
                    bx_next    = GRID_BITS'(s_x);
                    by_next    = GRID_BITS'(s_y);
                    bz_next    = GRID_BITS'(s_z);
                    kind_next  = KIND_WIDTH'(s_kind);
                    iss_next   = NB_CENTRE;
                    occ_c_next = 1'b0;
                    encl_next  = 1'b1;
                    priority if (!s_in_grid) begin
                        state_next = ST_DONE;
                    end else if (s_op == OP_PLACE || s_op == OP_DELETE) begin
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_WRITE: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                if (iss_reg != NB_END) begin
                    cap_vld_next = 1'b1;
                    cap_ctr_next = (iss_reg == NB_CENTRE);
                    cap_in_next  = nb_in_grid;
                    iss_next     = iss_reg + NB_SEL_W'(1);
                end else begin
                    state_next = ST_DONE;
                end
                if (cap_vld_reg) begin
                    if (cap_ctr_reg) begin
                        occ_c_next  = occ_rdata;
                        kind_c_next = kind_rdata;
                    end else begin
                        encl_next = encl_reg && cap_in_reg && occ_rdata;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, res_shown, res_kind, res_present};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cap_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cap_vld_reg  <= cap_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        op_reg      <= op_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        bz_reg      <= bz_next;
        kind_reg    <= kind_next;
        iss_reg     <= iss_next;
        cap_ctr_reg <= cap_ctr_next;
        cap_in_reg  <= cap_in_next;
        occ_c_reg   <= occ_c_next;
        kind_c_reg  <= kind_c_next;
        encl_reg    <= encl_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vgvs_checker.sv @@
// ----------------------------------------------------------------------------
// vgvs_checker
// Port-level checks for the voxel grid visibility store, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vgvs_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [vgvs_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [vgvs_pkg::M_TDATA_W-1:0] m_tdata
);
    import vgvs_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("reset did not clear handshake state");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[M_USED_W-1:1] == '0)
        else $error("empty cell reports kind or visibility");

endmodule

bind voxel_grid_visibility_store_core vgvs_checker u_vgvs_checker (.*);

`default_nettype wire

@@ tb/vgvs_grid_checker.sv @@
// ----------------------------------------------------------------------------
// vgvs_grid_checker
// Watches both stream channels of the voxel grid store. It keeps its own
// copy of the occupancy, visibility and kind of every cell. For each input
// transfer it works out the cell result that the store should return. Each
// output transfer is compared field by field with the oldest expected cell
// result. Mismatches and unexpected results are counted as errors.
// ----------------------------------------------------------------------------
`default_nettype none

module vgvs_grid_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    // op[1:0], pos_x[5:2], pos_y[9:6], pos_z[13:10], block_kind[21:14]
    input  wire logic [vgvs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // present[0], kind_out[8:1], shown[9]
    input  wire logic [vgvs_pkg::M_TDATA_W-1:0] m_tdata,
    output int                                  errors,
    output int                                  pending,
    output int                                  results,
    output int                                  hidden_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    import vgvs_pkg::*;

    localparam int SIDE      = 1 << GRID_BITS_DEF;
    localparam int CELLS     = SIDE * SIDE * SIDE;

    typedef struct packed {
        logic              present;
        logic [KIND_W-1:0] kind;
        logic              shown;
    } cell_result_t;

    bit                occ_map  [CELLS];
    bit                vis_map  [CELLS];
    logic [KIND_W-1:0] kind_map [CELLS];
    cell_result_t      cell_result_q [$];

    function automatic bit in_grid(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 && x < SIDE && y < SIDE && z < SIDE;
    endfunction

    function automatic int cell_addr(int x, int y, int z);
        return (z * SIDE + y) * SIDE + x;
    endfunction

    function automatic bit is_filled(int x, int y, int z);
        if (!in_grid(x, y, z))
            return 1'b0;
        return occ_map[cell_addr(x, y, z)];
    endfunction

    function automatic void refresh_cell(int x, int y, int z);
        int a;
        bit enclosed;
        if (!in_grid(x, y, z))
            return;
        a = cell_addr(x, y, z);
        if (!occ_map[a]) begin
            vis_map[a] = 1'b0;
        end else begin
            enclosed = is_filled(x - 1, y, z) && is_filled(x + 1, y, z) &&
                       is_filled(x, y - 1, z) && is_filled(x, y + 1, z) &&
                       is_filled(x, y, z - 1) && is_filled(x, y, z + 1);
            vis_map[a] = !enclosed;
        end
    endfunction

    function automatic void refresh_around(int x, int y, int z);
        refresh_cell(x, y, z);
        refresh_cell(x - 1, y, z);
        refresh_cell(x + 1, y, z);
        refresh_cell(x, y - 1, z);
        refresh_cell(x, y + 1, z);
        refresh_cell(x, y, z - 1);
        refresh_cell(x, y, z + 1);
    endfunction

    function automatic cell_result_t apply_cell_op(logic [S_TDATA_W-1:0] word);
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] kind;
        int                x;
        int                y;
        int                z;
        int                a;
        cell_result_t      r;
        op   = word[S_OP_LSB +: OP_W];
        x    = int'(word[S_X_LSB +: POS_W]);
        y    = int'(word[S_Y_LSB +: POS_W]);
        z    = int'(word[S_Z_LSB +: POS_W]);
        kind = word[S_KIND_LSB +: KIND_W];
        r    = '0;
        if (!in_grid(x, y, z))
            return r;
        a = cell_addr(x, y, z);
        if (op == OP_PLACE) begin
            occ_map[a]  = 1'b1;
            kind_map[a] = kind;
            refresh_around(x, y, z);
        end else if (op == OP_DELETE) begin
            occ_map[a]  = 1'b0;
            vis_map[a]  = 1'b0;
            kind_map[a] = '0;
            refresh_around(x, y, z);
        end
        if (occ_map[a]) begin
            r.present = 1'b1;
            r.kind    = kind_map[a];
            r.shown   = vis_map[a];
        end
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        cell_result_t want;
        cell_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                occ_map[i]  = 1'b0;
                vis_map[i]  = 1'b0;
                kind_map[i] = '0;
            end
            cell_result_q.delete();
            errors      = 0;
            results     = 0;
            hidden_seen = 0;
        end else begin
            if (s_tvalid && s_tready)
                cell_result_q.insert(cell_result_q.size(), apply_cell_op(s_tdata));
            if (m_tvalid && m_tready) begin
                got.present = m_tdata[0];
                got.kind    = m_tdata[KIND_W:1];
                got.shown   = m_tdata[KIND_W+1];
                results++;
                if (got.present && !got.shown)
                    hidden_seen++;
                if (cell_result_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with none expected, actual %h",
                             $realtime, m_tdata);
                end else begin
                    want = cell_result_q.pop_front();
                    check_field("present", want.present, got.present);
                    check_field("kind_out", want.kind, got.kind);
                    check_field("shown", want.shown, got.shown);
                end
            end
        end
        pending = cell_result_q.size();
    end

endmodule

`default_nettype wire

@@ tb/tb_voxel_grid_visibility_store_core.sv @@
// ----------------------------------------------------------------------------
// tb_voxel_grid_visibility_store_core
// Drives place, delete and query transfers into the voxel grid store. A short
// directed part covers the grid corners, kind extremes, overwrite, deleting
// an empty cell, the spare op code and a fully enclosed cell. Random bursts
// then work inside small boxes so that cells become enclosed and exposed
// again. Both channels stall at random, and the result side holds off once
// for a long stretch. The checker beside the store predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voxel_grid_visibility_store_core;

    timeunit 1ns;
    timeprecision 1ps;

    import vgvs_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int BURST_LEN    = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int errors;
    int pending;
    int results;
    int hidden_seen;
    int items_sent = 0;
    bit s_quiet    = 1'b0;

    voxel_grid_visibility_store_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vgvs_grid_checker u_grid_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .pending     (pending),
        .results     (results),
        .hidden_seen (hidden_seen)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // hold off once for a long stretch, and later run without stalls for a while
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results >= 200) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (results >= 350 && results < 450) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_cell_op(logic [OP_W-1:0] op, int x, int y, int z,
                                logic [KIND_W-1:0] kind);
        if (!s_quiet && $urandom_range(99) < 22) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tdata                = '0;
        s_tdata[S_USED_W-1:0]  = {kind, z[POS_W-1:0], y[POS_W-1:0], x[POS_W-1:0], op};
        s_tvalid               = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic int edge_biased_corner();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 13 : 0;
        return $urandom_range(13);
    endfunction

    initial begin : stimulus
        int r;
        int bx;
        int by;
        int bz;
        logic [OP_W-1:0] op;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_cell_op(OP_QUERY, 0, 0, 0, 8'hAA);
        send_cell_op(OP_PLACE, 0, 0, 0, 8'h00);
        send_cell_op(OP_PLACE, 15, 15, 15, 8'hFF);
        send_cell_op(OP_PLACE, 0, 0, 0, 8'h5A);
        send_cell_op(OP_DELETE, 3, 3, 3, 8'hC3);
        send_cell_op(OP_PLACE, 7, 7, 7, 8'h81);
        send_cell_op(OP_PLACE, 6, 7, 7, 8'h01);
        send_cell_op(OP_PLACE, 8, 7, 7, 8'h02);
        send_cell_op(OP_PLACE, 7, 6, 7, 8'h04);
        send_cell_op(OP_PLACE, 7, 8, 7, 8'h08);
        send_cell_op(OP_PLACE, 7, 7, 6, 8'h10);
        send_cell_op(OP_PLACE, 7, 7, 8, 8'h20);
        send_cell_op(OP_QUERY, 7, 7, 7, 8'h00);
        send_cell_op(OP_SPARE, 7, 7, 7, 8'hFF);
        send_cell_op(OP_DELETE, 8, 7, 7, 8'h7E);
        send_cell_op(OP_QUERY, 7, 7, 7, 8'h00);
        send_cell_op(OP_PLACE, 8, 7, 7, 8'hE7);
        send_cell_op(OP_QUERY, 7, 7, 7, 8'h00);
        send_cell_op(OP_DELETE, 0, 0, 0, 8'h00);
        send_cell_op(OP_QUERY, 0, 0, 0, 8'h00);
        send_cell_op(OP_QUERY, 15, 15, 15, 8'h00);

        bx = 0;
        by = 0;
        bz = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BURST_LEN == 0) begin
                bx = edge_biased_corner();
                by = edge_biased_corner();
                bz = edge_biased_corner();
            end
            s_quiet = (n >= 250 && n < 350);
            r = $urandom_range(99);
            if (r < 10) begin
                send_cell_op(OP_W'($urandom_range(3)), $urandom_range(15),
                             $urandom_range(15), $urandom_range(15),
                             KIND_W'($urandom_range(255)));
            end else begin
                r = $urandom_range(99);
                if (r < 58)
                    op = OP_PLACE;
                else if (r < 73)
                    op = OP_DELETE;
                else if (r < 95)
                    op = OP_QUERY;
                else
                    op = OP_SPARE;
                send_cell_op(op, bx + $urandom_range(2), by + $urandom_range(2),
                             bz + $urandom_range(2), KIND_W'($urandom_range(255)));
            end
        end
        s_tvalid = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d transfers of place, delete and query; checked %0d cell results.",
                 items_sent, results);
        $display("%0d results came from occupied cells enclosed on all six faces.",
                 hidden_seen);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ voxel_grid_visibility_store_core.f @@
hw/rtl/vgvs_pkg.sv
hw/rtl/vgvs_ram.sv
hw/rtl/vgvs_nbr_unit.sv
hw/rtl/voxel_grid_visibility_store_core.sv
hw/rtl/vgvs_checker.sv
tb/vgvs_grid_checker.sv
tb/tb_voxel_grid_visibility_store_core.sv
